/* rtl/core/nfcfb_pkg.sv */
// Shared types and constants for the NFC command frame builder.
// Used by nfcfb_front, nfcfb_queue, nfcfb_back and the top level.
`timescale 1ns / 1ps

package nfcfb_pkg;

   // Request command codes
   localparam logic CmdStart = 1'b0;
   localparam logic CmdData  = 1'b1;

   // Fixed frame bytes
   localparam logic [7:0] DirReset     = 8'hD4;
   localparam logic [7:0] PreambleByte = 8'h00;
   localparam logic [7:0] StartLoByte  = 8'h00;
   localparam logic [7:0] StartHiByte  = 8'hFF;
   localparam logic [7:0] PostambleByte = 8'h00;
   localparam logic [7:0] LenOffset    = 8'd2;

   // Byte positions within a frame, as walked by the back end.
   // A data job starts at PosFirst so that it shares the tail of the header walk.
   localparam int StepWidth = 4;
   localparam logic [StepWidth-1:0] PosPreamble  = 4'd0;
   localparam logic [StepWidth-1:0] PosStartLo   = 4'd1;
   localparam logic [StepWidth-1:0] PosStartHi   = 4'd2;
   localparam logic [StepWidth-1:0] PosLen       = 4'd3;
   localparam logic [StepWidth-1:0] PosLcs       = 4'd4;
   localparam logic [StepWidth-1:0] PosDir       = 4'd5;
   localparam logic [StepWidth-1:0] PosFirst     = 4'd6;
   localparam logic [StepWidth-1:0] PosDcs       = 4'd7;
   localparam logic [StepWidth-1:0] PosPostamble = 4'd8;

   // Queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // One unit of work for the back end
   typedef struct packed {
      logic       is_header;   // header walk, else a single data byte
      logic       trailer;     // append DCS and postamble
      logic [7:0] first_byte;  // command code or payload byte
      logic [7:0] len_byte;
      logic [7:0] lcs_byte;
      logic [7:0] dir_byte;
      logic [7:0] dcs_byte;
   } job_type;

endpackage

/* rtl/core/nfcfb_front.sv */
// Front end: accepts requests, tracks frame state and builds jobs.
// Depends on nfcfb_pkg.
`timescale 1ns / 1ps

module nfcfb_front
   import nfcfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       command,
   input  logic [7:0] frame_command,
   input  logic [7:0] payload_length,
   input  logic [7:0] data_byte,
   input  logic [7:0] direction,
   output logic       push,
   output job_type    job
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] running_sum_ff, running_sum_in;

   logic [7:0] len_field;
   logic [7:0] start_sum;
   logic [7:0] data_sum;
   logic [7:0] left_next;

   always_comb begin
      len_field = payload_length + LenOffset;
      start_sum = direction + frame_command;
      data_sum  = running_sum_ff + data_byte;
      left_next = bytes_left_ff - 8'd1;

      job            = '0;
      push           = 1'b0;
      in_frame_in    = in_frame_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;

      if (command == CmdStart) begin
         job.is_header  = 1'b1;
         job.trailer    = (payload_length == 8'd0);
         job.first_byte = frame_command;
         job.len_byte   = len_field;
         job.lcs_byte   = 8'd0 - len_field;
         job.dir_byte   = direction;
         job.dcs_byte   = 8'd0 - start_sum;
         push           = accept;
         if (accept) begin
            in_frame_in    = (payload_length != 8'd0);
            bytes_left_in  = payload_length;
            running_sum_in = start_sum;
         end
      end else begin
         job.is_header  = 1'b0;
         job.trailer    = (left_next == 8'd0);
         job.first_byte = data_byte;
         job.dcs_byte   = 8'd0 - data_sum;
         // drop data outside a frame
         push           = accept && in_frame_ff;
         if (accept && in_frame_ff) begin
            running_sum_in = data_sum;
            bytes_left_in  = left_next;
            in_frame_in    = (left_next != 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         bytes_left_ff  <= 8'd0;
         running_sum_ff <= 8'd0;
      end else begin
         in_frame_ff    <= in_frame_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

/* rtl/core/nfcfb_queue.sv */
// Short job queue between the front and back ends.
// Depends on nfcfb_pkg.
`timescale 1ns / 1ps

module nfcfb_queue
   import nfcfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_job
);

   job_type                   slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]  count_ff, count_in;

   localparam logic [QueuePtrWidth-1:0] PtrLast = QueuePtrWidth'(QueueDepth - 1);
   localparam logic [QueueCntWidth-1:0] CntFull = QueueCntWidth'(QueueDepth);

   always_comb begin
      full      = (count_ff == CntFull);
      not_empty = (count_ff != '0);
      head_job  = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/core/nfcfb_back.sv */
// Back end: walks each job byte by byte into the response register.
// Depends on nfcfb_pkg.
`timescale 1ns / 1ps

module nfcfb_back
   import nfcfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_run_last
);

   logic [StepWidth-1:0] step_ff, step_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 end_ff, end_in;
   logic                 last_ff, last_in;

   logic                 fire;
   logic [StepWidth-1:0] pos;
   logic [StepWidth-1:0] last_pos;

   always_comb begin
      fire     = job_valid && (!valid_ff || !rsp_stall);
      pos      = job.is_header ? step_ff : step_ff + PosFirst;
      last_pos = job.trailer ? PosPostamble : PosFirst;

      case (pos)
         PosPreamble:  byte_in = PreambleByte;
         PosStartLo:   byte_in = StartLoByte;
         PosStartHi:   byte_in = StartHiByte;
         PosLen:       byte_in = job.len_byte;
         PosLcs:       byte_in = job.lcs_byte;
         PosDir:       byte_in = job.dir_byte;
         PosFirst:     byte_in = job.first_byte;
         PosDcs:       byte_in = job.dcs_byte;
         PosPostamble: byte_in = PostambleByte;
         default:      byte_in = PostambleByte;
      endcase

      end_in  = (pos == PosPostamble);
      last_in = (pos == last_pos);
      pop     = fire && last_in;

      // advance through the job; restart at the head of the next one
      step_in = step_ff;
      if (fire) begin
         step_in = last_in ? '0 : step_ff + 1'b1;
      end

      // hold the response while it is stalled
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_run_last  = last_ff;

endmodule

/* rtl/core/nfc_command_frame_builder.sv */
// Top level of the NFC command frame builder: front end, job queue, back end.
// Depends on nfcfb_pkg, nfcfb_front, nfcfb_queue and nfcfb_back.
`timescale 1ns / 1ps

//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------------
//  req_     | in        | req_valid/req_stall | command, frame_command,
//           |           |                     | payload_length, data_byte
//  rsp_     | out       | rsp_valid/rsp_stall | out_byte, frame_end, run_last
//  csr_     | in        | csr_write_enable    | csr_write_data (direction code)
//
//  A request is taken whenever the four-entry job queue has room; the back end then
//  sends one byte per cycle while rsp_stall is low: one for a data request, three
//  when it closes the frame, seven for a start request (nine with an empty payload).
//  The sustained rate is set by the back end's single byte-wide response register.
//  Reset (synchronous, active high) empties the queue, clears the frame state and
//  loads the direction code with D4. A stalled response holds; requests pile up in
//  the queue and req_stall rises only once it is full.

module nfc_command_frame_builder
   import nfcfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_frame_command,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_data_byte,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_run_last,
   // configuration
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0] direction_ff;
   logic       accept;
   logic       push;
   logic       pop;
   logic       queue_full;
   logic       queue_not_empty;
   job_type    new_job;
   job_type    head_job;

   // Direction byte: taken into each job at its start request
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DirReset;
      end else if (csr_write_enable) begin
         direction_ff <= csr_write_data;
      end
   end

   // Stall only on a full queue; a data request outside a frame is still
   // accepted and simply dropped by the front end.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   nfcfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .command        (req_command),
      .frame_command  (req_frame_command),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .direction      (direction_ff),
      .push           (push),
      .job            (new_job)
   );

   nfcfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (new_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   nfcfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (queue_not_empty),
      .job           (head_job),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

/* bench/testbench.sv */
// Self-checking bench for nfc_command_frame_builder: directed and random requests,
// with each response byte checked against a frame predictor kept in the bench.
// Depends on nfcfb_pkg and the nfc_command_frame_builder RTL.
`timescale 1ns / 1ps

module testbench;
   import nfcfb_pkg::*;

   // Cycles to hold after the last expected byte before the block counts as idle:
   // covers the four-entry job queue plus the back-end response register.
   localparam int DRAIN_CYCLES = 16;
   // Cycles without any handshake on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_REQUESTS = 30;

   typedef struct packed {
      logic [7:0] value;
      logic       frame_end;
      logic       run_last;
   } frame_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_command = CmdStart;
   logic [7:0] req_frame_command = 8'h00;
   logic [7:0] req_payload_length = 8'h00;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_end;
   logic       rsp_run_last;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   // Predicted frame state, mirrored from the block's behaviour
   logic [7:0] pred_direction = DirReset;
   logic       pred_in_frame = 1'b0;
   logic [7:0] pred_bytes_left = 8'h00;
   logic [7:0] pred_running_sum = 8'h00;

   frame_byte_type frame_bytes_due[$];
   int             error_count = 0;
   int             quiet_cycles = 0;
   int             stall_left = 0;
   bit             gaps_on = 1'b1;
   bit             stalls_on = 1'b1;

   nfc_command_frame_builder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_frame_command  (req_frame_command),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_run_last       (rsp_run_last),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Work out the bytes one accepted request should produce and queue them.
   // A start request always emits the seven header bytes, abandoning any open
   // frame; a data request outside a frame emits nothing and leaves state alone.
   task automatic build_frame_bytes(input logic cmd, input logic [7:0] code,
                                    input logic [7:0] length, input logic [7:0] data);
      frame_byte_type burst[$];
      frame_byte_type last;
      logic [7:0]     len_field;
      logic           closes;
      closes = 1'b0;
      if (cmd == CmdStart) begin
         len_field = length + LenOffset;   // wraps for lengths 254 and 255
         burst.push_back('{PreambleByte, 1'b0, 1'b0});
         burst.push_back('{StartLoByte, 1'b0, 1'b0});
         burst.push_back('{StartHiByte, 1'b0, 1'b0});
         burst.push_back('{len_field, 1'b0, 1'b0});
         burst.push_back('{8'h00 - len_field, 1'b0, 1'b0});
         burst.push_back('{pred_direction, 1'b0, 1'b0});
         burst.push_back('{code, 1'b0, 1'b0});
         pred_running_sum = pred_direction + code;
         pred_bytes_left = length;
         pred_in_frame = 1'b1;
         closes = (length == 8'h00);
      end else if (pred_in_frame) begin
         burst.push_back('{data, 1'b0, 1'b0});
         pred_running_sum = pred_running_sum + data;
         pred_bytes_left = pred_bytes_left - 8'h01;
         closes = (pred_bytes_left == 8'h00);
      end
      if (closes) begin
         burst.push_back('{8'h00 - pred_running_sum, 1'b0, 1'b0});
         burst.push_back('{PostambleByte, 1'b1, 1'b0});
         pred_in_frame = 1'b0;
         pred_bytes_left = 8'h00;
      end
      if (burst.size() > 0) begin
         last = burst.pop_back();
         last.run_last = 1'b1;
         burst.push_back(last);
      end
      foreach (burst[i])
         frame_bytes_due.push_back(burst[i]);
   endtask

   // Offer one request, hold it until accepted, then predict its bytes.
   // Valid is only dropped when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(input logic cmd, input logic [7:0] code,
                               input logic [7:0] length, input logic [7:0] data);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_frame_command <= code;
      req_payload_length <= length;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      build_frame_bytes(cmd, code, length, data);
   endtask

   // Unused fields carry random junk so that the block is seen to ignore them.
   task automatic send_start(input logic [7:0] code, input logic [7:0] length);
      send_request(CmdStart, code, length, 8'($urandom));
   endtask

   task automatic send_data(input logic [7:0] data);
      send_request(CmdData, 8'($urandom), 8'($urandom), data);
   endtask

   // Drop valid and hold until every predicted byte has arrived, then let the
   // pipeline drain any requests that produce no bytes.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do begin
         while (frame_bytes_due.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end while (frame_bytes_due.size() != 0);
   endtask

   task automatic write_direction(input logic [7:0] value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pred_direction = value;
   endtask

   // Stray data with no frame open, empty payloads, stray data after a closed frame.
   task automatic test_empty_frames();
      send_data(8'hA5);
      send_start(8'h00, 8'd0);
      send_start(8'hFF, 8'd0);
      send_data(8'h3C);
   endtask

   task automatic test_short_frames();
      send_start(8'h4A, 8'd1);
      send_data(8'hFF);
      send_start(8'h02, 8'd2);
      send_data(8'h00);
      send_data(8'h80);
   endtask

   // LEN wraps for the two longest lengths; each long frame is abandoned by the
   // next start, and the last one is closed normally.
   task automatic test_length_wrap();
      send_start(8'h40, 8'd254);
      send_data(8'h11);
      send_start(8'h14, 8'd255);
      send_start(8'h60, 8'd3);
      send_data(8'hC3);
      send_start(8'h8C, 8'd1);
      send_data(8'h7E);
   endtask

   // Direction byte at both extremes, then changed while a frame is open: the old
   // value stays in the checksum of that frame, the new one applies to the next.
   task automatic test_direction_register();
      write_direction(8'h00);
      send_start(8'h01, 8'd1);
      send_data(8'h55);
      write_direction(8'hFF);
      send_start(8'hFE, 8'd1);
      send_data(8'hAA);
      send_start(8'h32, 8'd2);
      send_data(8'h01);
      write_direction(8'h5A);
      send_data(8'hFE);
      send_start(8'h4C, 8'd0);
      write_direction(DirReset);
   endtask

   // Mostly well-formed frames with random content, some broken off early, some
   // stray data, occasional register writes and full pauses, with idling toggled.
   task automatic test_random_traffic();
      int         sent;
      int         keep;
      int         r;
      logic [7:0] length;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         gaps_on = ($urandom_range(0, 5) != 0);
         stalls_on = ($urandom_range(0, 5) != 0);
         r = $urandom_range(0, 99);
         if (r < 4) begin
            write_direction(8'($urandom));
         end else if (r < 8) begin
            wait_until_drained();
         end else if (r < 16) begin
            send_data(8'($urandom));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8)
               length = 8'd0;
            else if (r < 78)
               length = 8'($urandom_range(1, 6));
            else if (r < 95)
               length = 8'($urandom_range(7, 24));
            else
               length = 8'($urandom_range(250, 255));
            keep = int'(length);
            if (length >= 8'd250 || $urandom_range(0, 9) == 0)
               keep = int'($urandom_range(0, (length < 8'd8) ? int'(length) : 8));
            send_start(8'($urandom), length);
            sent++;
            repeat (keep) begin
               send_data(8'($urandom));
               sent++;
            end
         end
      end
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   // One frame of the greatest length, run to completion so the count runs out.
   task automatic test_full_length_frame();
      send_start(8'($urandom), 8'd255);
      repeat (255) send_data(8'($urandom));
   endtask

   // Response side: check each accepted byte against the oldest prediction and
   // stall at random, with runs of no stalling when stalls are switched off.
   always @(posedge clock) begin : response_side
      frame_byte_type want;
      int             n;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected response: out_byte %02h frame_end %0b run_last %0b",
                   rsp_out_byte, rsp_frame_end, rsp_run_last);
            error_count++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_out_byte !== want.value) begin
               $error("out_byte: expected %02h, got %02h", want.value, rsp_out_byte);
               error_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
               error_count++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
               error_count++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         n = stalls_on ? pick_gap() : 0;
         rsp_stall <= (n != 0);
         stall_left <= (n == 0) ? 0 : n - 1;
      end
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_frames();
      test_short_frames();
      test_length_wrap();
      test_direction_register();
      test_random_traffic();
      test_full_length_frame();
      wait_until_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
rtl/core/nfcfb_pkg.sv
rtl/core/nfcfb_front.sv
rtl/core/nfcfb_queue.sv
rtl/core/nfcfb_back.sv
rtl/core/nfc_command_frame_builder.sv
bench/testbench.sv
